/* sv/fcv_pkg.sv */
// Shared types, codes and helpers for the Verlet chain integrator.
package fcv_pkg;

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE,
    ST_A_START, ST_A_LOAD0, ST_A_RD, ST_A_DIFF,
    ST_A_M1, ST_A_M2, ST_A_M3, ST_A_M4, ST_A_W1, ST_A_W2,
    ST_K_RD, ST_K_MUL, ST_K_W1, ST_K_W2,
    ST_D_RD, ST_D_MUL, ST_D_W1, ST_D_W2,
    ST_R_RD, ST_R_LOAD
  } state_t;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  localparam logic [1:0] REG_TIME_STEP = 2'd0;
  localparam logic [1:0] REG_STIFFNESS = 2'd1;
  localparam logic [1:0] REG_NONLINEAR = 2'd2;

  localparam logic [23:0] TIME_STEP_RST = 24'd2516582;
  localparam logic [31:0] STIFFNESS_RST = 32'd16777216;
  localparam logic [31:0] NONLINEAR_RST = 32'd1677722;

  typedef struct packed {
    logic signed [31:0] value;
    logic               ovf;
  } sat_t;

  // Clamp a 33-bit sum to the signed 32-bit range.
  function automatic sat_t sat33(input logic signed [32:0] x);
    sat_t r;
    r.ovf = x[32] ^ x[31];
    if (!r.ovf) r.value = x[31:0];
    else if (x[32]) r.value = 32'sh8000_0000;
    else r.value = 32'sh7FFF_FFFF;
    return r;
  endfunction

endpackage

/* sv/fcv_mul.sv */
// Two-stage signed multiplier: product >> 24 or >> 25, round half away, saturate.
module fcv_mul import fcv_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  logic signed [35:0] a,
  input  logic signed [35:0] b,
  input  logic               sh25,
  output logic signed [31:0] res,
  output logic               sat,
  output logic               done
);

  logic [34:0] am, bm;
  logic [69:0] prod;
  logic        neg1, sh1, v1;
  logic [70:0] t;
  logic [46:0] r, lim;
  logic        ovf;
  logic [31:0] mag;

  assign am = a[35] ? 35'(-a) : a[34:0];
  assign bm = b[35] ? 35'(-b) : b[34:0];

  always_ff @(posedge clk) begin
    prod <= am * bm;
    neg1 <= a[35] ^ b[35];
    sh1  <= sh25;
  end

  always_comb begin
    t   = {1'b0, prod} + (sh1 ? (71'd1 << 24) : (71'd1 << 23));
    r   = sh1 ? {1'b0, t[70:25]} : t[70:24];
    lim = neg1 ? 47'h0_8000_0000 : 47'h0_7FFF_FFFF;
    ovf = r > lim;
    mag = ovf ? lim[31:0] : r[31:0];
  end

  always_ff @(posedge clk) begin
    res <= neg1 ? -$signed(mag) : $signed(mag);
    sat <= ovf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= go;
      done <= v1;
    end
  end

endmodule

/* sv/fpu_chain_verlet_step_unit.sv */
// Top level: velocity Verlet integrator for a fixed-end alpha chain.
//
// channel | dir | transfer when          | payload
// s_*     | in  | s_tvalid & s_tready    | tuser command, tdata index/pos/vel/steps
// m_*     | out | m_tvalid & m_tready    | tdata index/pos/vel, tuser sat, tlast
// cfg_*   | in  | cfg_valid & cfg_ready  | cfg_index register, cfg_data value
//
// Sequence: a load writes one particle while idle. An advance runs a force
// pass, then per step a half kick, a drift, a force pass and a second half
// kick, and then reads out every particle. The force pass is bound by the
// single shared multiplier (three products per particle) and one read port
// on the position memory.
// Reset: a clearing pass zeroes positions and velocities; s_tready stays
// low during it. Config is always ready.
// Stalls: readout holds on m_tready; the next advance waits for it.
module fpu_chain_verlet_step_unit import fcv_pkg::*; #(
  parameter int PARTICLES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,   // particle_index[4:0], position[36:5],
                                 // velocity[68:37], step_count[84:69], zero pad
  input  logic        s_tuser,   // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // particle_index_res[4:0], position_res[36:5],
                                 // velocity_res[68:37], zero pad
  output logic        m_tuser,   // saturated
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int IW = $clog2(PARTICLES);
  localparam logic [IW-1:0] LAST_IDX = IW'(PARTICLES - 1);

  state_t state, state_next;

  // Parameter registers
  logic [23:0] time_step;
  logic [31:0] stiffness;
  logic signed [31:0] nonlinear;

  // State memories, one read port (registered) and one write port each
  logic signed [31:0] pos_mem [PARTICLES];
  logic signed [31:0] vel_mem [PARTICLES];
  logic signed [31:0] acc_mem [PARTICLES];
  logic signed [31:0] pos_rd, vel_rd, acc_rd;
  logic          pos_re, vel_re, acc_re, pos_we, vel_we, acc_we;
  logic [IW-1:0] pos_ra, pos_wa;
  logic signed [31:0] pos_wd, vel_wd;

  // Sequencer
  logic [IW-1:0] idx;
  logic [15:0]   steps;
  logic          init_pass, second_kick, flag;
  logic          is_last;

  // Force pass window
  logic signed [31:0] left, center, right;
  logic signed [35:0] dd, ds;
  logic signed [31:0] lin, hold;

  // Multiplier
  logic               mul_go, mul_sh25, mul_sat, mul_done;
  logic signed [35:0] mul_a, mul_b;
  logic signed [31:0] mul_res;

  sat_t sum;
  logic wb_ovf, load_out;
  logic in_fire;
  logic [IW-1:0] ld_idx;
  logic          ld_ok;
  logic signed [31:0] right_new;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = s_tvalid && s_tready;
  assign is_last   = (idx == LAST_IDX);
  assign ld_ok     = 32'(s_tdata[4:0]) < PARTICLES;
  assign ld_idx    = IW'(s_tdata[4:0]);
  assign load_out  = (state == ST_R_LOAD) && (!m_tvalid || m_tready);
  assign right_new = is_last ? 32'sd0 : pos_rd;
  // sum clamps only count in the write-back states
  assign wb_ovf    = sum.ovf && (state == ST_A_W2 || state == ST_K_W2 ||
                                 state == ST_D_W2);

  fcv_mul u_mul (
    .clk (clk), .rst (rst), .go (mul_go), .a (mul_a), .b (mul_b),
    .sh25 (mul_sh25), .res (mul_res), .sat (mul_sat), .done (mul_done)
  );

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= TIME_STEP_RST;
      stiffness <= STIFFNESS_RST;
      nonlinear <= NONLINEAR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TIME_STEP: time_step <= cfg_data[23:0];
        REG_STIFFNESS: stiffness <= cfg_data;
        REG_NONLINEAR: nonlinear <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next state, memory controls and multiplier operands
  always_comb begin
    state_next = state;
    pos_re = 1'b0; vel_re = 1'b0; acc_re = 1'b0;
    pos_we = 1'b0; vel_we = 1'b0; acc_we = 1'b0;
    pos_ra = idx;  pos_wa = idx;
    pos_wd = 32'sd0; vel_wd = 32'sd0;
    mul_go = 1'b0; mul_sh25 = 1'b0;
    mul_a = 36'sd0; mul_b = 36'sd0;
    sum = sat33(33'(lin) + 33'(mul_res));
    case (state)
      ST_CLR: begin
        pos_we = 1'b1; vel_we = 1'b1;
        if (is_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (s_tuser == CMD_ADVANCE) begin
            state_next = ST_A_START;
          end else if (ld_ok) begin
            pos_we = 1'b1; vel_we = 1'b1; pos_wa = ld_idx;
            pos_wd = s_tdata[36:5]; vel_wd = s_tdata[68:37];
          end
        end
      end
      ST_A_START: begin
        pos_re = 1'b1; pos_ra = '0;
        state_next = ST_A_LOAD0;
      end
      ST_A_LOAD0: state_next = ST_A_RD;
      ST_A_RD: begin
        pos_re = !is_last; pos_ra = IW'(idx + 1'b1);
        state_next = ST_A_DIFF;
      end
      ST_A_DIFF: state_next = ST_A_M1;
      ST_A_M1: begin
        mul_go = 1'b1; mul_a = 36'(stiffness); mul_b = dd;
        state_next = ST_A_M2;
      end
      ST_A_M2: begin
        mul_go = 1'b1; mul_a = dd; mul_b = ds;
        state_next = ST_A_M3;
      end
      ST_A_M3: state_next = ST_A_M4;
      ST_A_M4: begin
        mul_go = 1'b1; mul_a = 36'(nonlinear); mul_b = 36'(mul_res);
        state_next = ST_A_W1;
      end
      ST_A_W1: state_next = ST_A_W2;
      ST_A_W2: begin
        acc_we = 1'b1;
        if (!is_last) state_next = ST_A_RD;
        else if (init_pass && steps == 16'd0) state_next = ST_R_RD;
        else state_next = ST_K_RD;
      end
      ST_K_RD: begin
        acc_re = 1'b1; vel_re = 1'b1;
        state_next = ST_K_MUL;
      end
      ST_K_MUL: begin
        mul_go = 1'b1; mul_sh25 = 1'b1;
        mul_a = 36'(time_step); mul_b = 36'(acc_rd);
        state_next = ST_K_W1;
      end
      ST_K_W1: state_next = ST_K_W2;
      ST_K_W2: begin
        sum = sat33(33'(hold) + 33'(mul_res));
        vel_we = 1'b1; vel_wd = sum.value;
        if (!is_last) state_next = ST_K_RD;
        else if (!second_kick) state_next = ST_D_RD;
        else if (steps == 16'd1) state_next = ST_R_RD;
        else state_next = ST_K_RD;
      end
      ST_D_RD: begin
        vel_re = 1'b1; pos_re = 1'b1;
        state_next = ST_D_MUL;
      end
      ST_D_MUL: begin
        mul_go = 1'b1;
        mul_a = 36'(time_step); mul_b = 36'(vel_rd);
        state_next = ST_D_W1;
      end
      ST_D_W1: state_next = ST_D_W2;
      ST_D_W2: begin
        sum = sat33(33'(hold) + 33'(mul_res));
        pos_we = 1'b1; pos_wd = sum.value;
        state_next = is_last ? ST_A_START : ST_D_RD;
      end
      ST_R_RD: begin
        pos_re = 1'b1; vel_re = 1'b1;
        state_next = ST_R_LOAD;
      end
      ST_R_LOAD: begin
        if (load_out) state_next = is_last ? ST_IDLE : ST_R_RD;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLR;
    else state <= state_next;
  end

  // Memories
  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[pos_wa] <= pos_wd;
    if (vel_we) vel_mem[pos_wa] <= vel_wd;
    if (acc_we) acc_mem[idx] <= sum.value;
    if (pos_re) pos_rd <= pos_mem[pos_ra];
    if (vel_re) vel_rd <= vel_mem[idx];
    if (acc_re) acc_rd <= acc_mem[idx];
  end

  // Sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      steps <= '0;
      init_pass <= 1'b0;
      second_kick <= 1'b0;
      flag <= 1'b0;
    end else begin
      if ((mul_done && mul_sat) || wb_ovf) flag <= 1'b1;
      case (state)
        ST_CLR: idx <= is_last ? '0 : IW'(idx + 1'b1);
        ST_IDLE: begin
          if (in_fire && s_tuser == CMD_ADVANCE) begin
            flag <= 1'b0;
            steps <= s_tdata[84:69];
            init_pass <= 1'b1;
            second_kick <= 1'b0;
            idx <= '0;
          end
        end
        ST_A_W2: begin
          if (is_last) begin
            idx <= '0;
            init_pass <= 1'b0;
            second_kick <= !init_pass;
          end else begin
            idx <= IW'(idx + 1'b1);
          end
        end
        ST_K_W2: begin
          if (is_last) begin
            idx <= '0;
            if (second_kick) begin
              steps <= steps - 16'd1;
              second_kick <= 1'b0;
            end
          end else begin
            idx <= IW'(idx + 1'b1);
          end
        end
        ST_D_W2: idx <= is_last ? '0 : IW'(idx + 1'b1);
        ST_R_LOAD: if (load_out) idx <= is_last ? '0 : IW'(idx + 1'b1);
        default: ;
      endcase
    end
  end

  // Force pass window and operand holding
  always_ff @(posedge clk) begin
    case (state)
      ST_A_LOAD0: begin
        left <= 32'sd0;
        center <= pos_rd;
      end
      ST_A_DIFF: begin
        right <= right_new;
        dd <= 36'(right_new) - (36'(center) <<< 1) + 36'(left);
        ds <= 36'(right_new) - 36'(left);
      end
      ST_A_M3: lin <= mul_res;
      ST_A_W2: begin
        left <= center;
        center <= right;
      end
      ST_K_MUL: hold <= vel_rd;
      ST_D_MUL: hold <= pos_rd;
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (load_out) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {3'b000, vel_rd, pos_rd, 5'(idx)};
      m_tuser <= flag;
      m_tlast <= is_last;
    end
  end

  // Checks
  a_mul_consumed: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == ST_A_M3 || state == ST_A_M4 || state == ST_A_W2 ||
                  state == ST_K_W2 || state == ST_D_W2))
    else $error("multiplier result arrived outside a consuming state");

  a_readout_open: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (state == ST_R_RD || state == ST_R_LOAD))
    else $error("readout left before the last particle");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == CMD_ADVANCE) |=> (state == ST_A_START))
    else $error("advance did not start the force pass");

endmodule

/* tb/verlet_chain_checker.sv */
// Checker: predicts the chain integrator's readout and compares each result transfer.
module verlet_chain_checker import fcv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [87:0] s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [71:0] m_tdata,
  input  logic        m_tuser,
  input  logic        m_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          reports_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N = 32;
  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;

  typedef struct {
    logic [4:0]         idx;
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic               sat;
    logic               last;
  } particle_report_t;

  particle_report_t report_q[$];

  logic [23:0]        dt;
  logic [31:0]        kappa;
  logic signed [31:0] alpha;
  logic signed [31:0] disp[N];
  logic signed [31:0] speed[N];
  logic signed [31:0] accel[N];
  logic               sat_seen;

  assign reports_due = report_q.size();

  function automatic longint clamp32(longint v);
    if (v > QMAX) begin
      sat_seen = 1'b1;
      return QMAX;
    end
    if (v < QMIN) begin
      sat_seen = 1'b1;
      return QMIN;
    end
    return v;
  endfunction

  // (a*b) >> sh, rounded half away from zero, clamped to 32-bit signed
  function automatic longint fixed_mul(longint a, longint b, int sh);
    logic         neg;
    logic [63:0]  am, bm;
    logic [127:0] p, lim;
    neg = (a < 0) != (b < 0);
    am  = (a < 0) ? -a : a;
    bm  = (b < 0) ? -b : b;
    p   = {64'd0, am} * {64'd0, bm};
    p   = (p + (128'd1 << (sh - 1))) >> sh;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (p > lim) begin
      sat_seen = 1'b1;
      p = lim;
    end
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  task automatic chain_forces();
    longint c, lt, rt, dp, dm, lin, sq, nl;
    for (int i = 0; i < N; i++) begin
      c   = disp[i];
      lt  = (i > 0) ? longint'(disp[i-1]) : 0;
      rt  = (i < N - 1) ? longint'(disp[i+1]) : 0;
      dp  = rt - c;
      dm  = c - lt;
      lin = fixed_mul(longint'({32'd0, kappa}), dp - dm, 24);
      sq  = fixed_mul(dp - dm, dp + dm, 24);
      nl  = fixed_mul(longint'(alpha), sq, 24);
      accel[i] = 32'(clamp32(lin + nl));
    end
  endtask

  task automatic half_kick();
    longint k;
    for (int i = 0; i < N; i++) begin
      k = fixed_mul(longint'({40'd0, dt}), longint'(accel[i]), 25);
      speed[i] = 32'(clamp32(longint'(speed[i]) + k));
    end
  endtask

  task automatic advance_chain(int steps);
    particle_report_t r;
    longint d;
    sat_seen = 1'b0;
    chain_forces();
    for (int s = 0; s < steps; s++) begin
      half_kick();
      for (int i = 0; i < N; i++) begin
        d = fixed_mul(longint'({40'd0, dt}), longint'(speed[i]), 24);
        disp[i] = 32'(clamp32(longint'(disp[i]) + d));
      end
      chain_forces();
      half_kick();
    end
    for (int i = 0; i < N; i++) begin
      r.idx  = 5'(i);
      r.pos  = disp[i];
      r.vel  = speed[i];
      r.sat  = sat_seen;
      r.last = (i == N - 1);
      report_q.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    particle_report_t e;
    if (rst) begin
      dt         = TIME_STEP_RST;
      kappa      = STIFFNESS_RST;
      alpha      = NONLINEAR_RST;
      sat_seen   = 1'b0;
      fail_count = 0;
      report_q.delete();
      for (int i = 0; i < N; i++) begin
        disp[i]  = '0;
        speed[i] = '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TIME_STEP: dt = cfg_data[23:0];
          REG_STIFFNESS: kappa = cfg_data;
          REG_NONLINEAR: alpha = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == CMD_LOAD) begin
          // all 32 indexes are in range for this chain length
          disp[s_tdata[4:0]]  = s_tdata[36:5];
          speed[s_tdata[4:0]] = s_tdata[68:37];
        end else begin
          advance_chain(int'(s_tdata[84:69]));
        end
      end
      if (m_tvalid && m_tready) begin
        if (report_q.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_count++;
        end else begin
          e = report_q.pop_front();
          if (m_tdata[4:0] !== e.idx) begin
            $error("particle_index_res expected %0d got %0d", e.idx, m_tdata[4:0]);
            fail_count++;
          end
          if (m_tdata[36:5] !== e.pos) begin
            $error("position_res expected %h got %h", e.pos, m_tdata[36:5]);
            fail_count++;
          end
          if (m_tdata[68:37] !== e.vel) begin
            $error("velocity_res expected %h got %h", e.vel, m_tdata[68:37]);
            fail_count++;
          end
          if (m_tuser !== e.sat) begin
            $error("saturated expected %0b got %0b", e.sat, m_tuser);
            fail_count++;
          end
          if (m_tlast !== e.last) begin
            $error("last expected %0b got %0b", e.last, m_tlast);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

/* tb/tb.sv */
// Testbench top: stimulus, result back-pressure and verdict for the chain integrator.
module tb import fcv_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // no transfer for this many cycles means the block hung; the slowest
  // legal advance here has 40 steps
  localparam int QUIET_LIMIT = 80000;

  logic        clk, rst;
  logic        s_tvalid, s_tready, s_tuser;
  logic [87:0] s_tdata;
  logic        m_tvalid, m_tready, m_tuser, m_tlast;
  logic [71:0] m_tdata;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  int          fail_count, reports_due, quiet, rx_count;

  fpu_chain_verlet_step_unit dut (.*);

  verlet_chain_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly back to back, sometimes a short gap, rarely a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // all driving happens right after a falling edge
  task automatic send_item(logic cmd, logic [4:0] idx, logic [31:0] pos,
                           logic [31:0] vel, logic [15:0] steps);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_tvalid = 1'b0;
      repeat (g) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = cmd;
    s_tdata  = {3'd0, steps, vel, pos, idx};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // hold the sender until every readout has drained, then let the block settle
  task automatic drain();
    while (reports_due != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  // random displacement or velocity: mostly near the scale of 1.0
  function automatic logic [31:0] rand_q();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 32'($signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000);
    if (r < 85) return $urandom;
    if (r < 92) return 32'h7FFF_FFFF;
    return 32'h8000_0000;
  endfunction

  function automatic logic [15:0] rand_steps();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 16'($urandom_range(3));
    if (r < 95) return 16'($urandom_range(10, 4));
    return 16'($urandom_range(40, 20));
  endfunction

  task automatic random_phase(int items);
    for (int n = 0; n < items; n++) begin
      if ($urandom_range(5) == 0)
        // step count field is free on loads; advances get a bounded run length
        send_item(CMD_ADVANCE, 5'($urandom), $urandom, $urandom, rand_steps());
      else
        send_item(CMD_LOAD, 5'($urandom), rand_q(), rand_q(), 16'($urandom));
    end
  endtask

  // result side: random stalls plus one long hold-off while the sender keeps going
  initial begin
    int g;
    m_tready = 1'b0;
    rx_count = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      g = gap_len();
      if (rx_count >= 200 && rx_count < 232) begin
        g = 600;
        rx_count = 232;
      end
      m_tready = 1'b0;
      repeat (g) @(negedge clk);
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
      rx_count++;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet == QUIET_LIMIT) begin
      $display("[fpu_chain_verlet_step_unit] ERROR");
      $finish;
    end
  end

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tuser   = CMD_LOAD;
    s_tdata   = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_TIME_STEP;
    cfg_data  = '0;
    quiet     = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset config, field extremes, zero and small step counts
    send_item(CMD_ADVANCE, 5'd0, '0, '0, 16'd0);
    send_item(CMD_LOAD, 5'd0, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
    send_item(CMD_LOAD, 5'd31, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0000);
    send_item(CMD_ADVANCE, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0);
    send_item(CMD_ADVANCE, 5'd0, '0, '0, 16'd1);
    send_item(CMD_LOAD, 5'd0, 32'h0100_0000, 32'h0, 16'h5555);
    send_item(CMD_LOAD, 5'd31, 32'hFF00_0000, 32'h0080_0000, 16'hAAAA);
    send_item(CMD_LOAD, 5'd16, 32'h0080_0000, 32'hFF80_0000, 16'd0);
    send_item(CMD_ADVANCE, 5'd7, 32'h1234_5678, 32'h8765_4321, 16'd3);
    // zero steps reads out without moving; flag restarts clear
    send_item(CMD_ADVANCE, 5'd0, '0, '0, 16'd0);
    drain();

    // phases through register extremes, then random settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_TIME_STEP, 32'h00FF_FFFF);
          write_reg(REG_STIFFNESS, 32'h0);
          write_reg(REG_NONLINEAR, 32'h8000_0000);
        end
        1: begin
          write_reg(REG_TIME_STEP, 32'h0);
          write_reg(REG_STIFFNESS, 32'hFFFF_FFFF);
          write_reg(REG_NONLINEAR, 32'h7FFF_FFFF);
        end
        2: begin
          write_reg(REG_TIME_STEP, 32'h0004_0000);
          write_reg(REG_STIFFNESS, 32'h0100_0000);
          write_reg(REG_NONLINEAR, 32'h0);
        end
        3, 4: begin
          write_reg(REG_TIME_STEP, $urandom_range(32'h0040_0000));
          write_reg(REG_STIFFNESS, $urandom_range(32'h0400_0000));
          write_reg(REG_NONLINEAR, 32'($signed($urandom_range(32'h0200_0000)) -
                                      32'sh0100_0000));
        end
        default: begin
          write_reg(REG_TIME_STEP, $urandom);
          write_reg(REG_STIFFNESS, $urandom);
          write_reg(REG_NONLINEAR, $urandom);
        end
      endcase
      random_phase(58);
      drain();
    end

    repeat (40) @(posedge clk);
    if (fail_count == 0 && reports_due == 0)
      $display("[fpu_chain_verlet_step_unit] OK");
    else
      $display("[fpu_chain_verlet_step_unit] ERROR");
    $finish;
  end

endmodule

/* files.f */
sv/fcv_pkg.sv
sv/fcv_mul.sv
sv/fpu_chain_verlet_step_unit.sv
tb/verlet_chain_checker.sv
tb/tb.sv
